FILE: hdl/lpbp_pkg.sv
`default_nettype none

package lpbp_pkg;

  localparam int unsigned PageW = 32;
  localparam int unsigned TableW = 8;
  localparam int unsigned CapW = 5;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;
  localparam logic [CapW-1:0] CapReset = 5'd16;

  typedef enum logic {
    REQ_LOOKUP = 1'b0,
    REQ_FLUSH  = 1'b1
  } req_type_e;

  // Register index taken from the word address bit of paddr (paddr[2]).
  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_NONE     = 1'b1
  } reg_index_e;

  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_CMP   = 2'd1,
    OP_SHIFT = 2'd2,
    OP_ROT   = 2'd3
  } cell_op_e;

  typedef enum logic [1:0] {
    UPD_HIT    = 2'd0,
    UPD_INSERT = 2'd1,
    UPD_EVICT  = 2'd2
  } upd_kind_e;

  typedef struct packed {
    logic              valid;
    logic [PageW-1:0]  page;
    logic [TableW-1:0] tbl;
  } entry_t;

  typedef struct packed {
    cell_op_e  op;
    upd_kind_e kind;
    logic      keep;
    logic      pick_tail;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/lru_page_buffer_pool.sv
`default_nettype none

// Channel   | Direction | Handshake                      | Payload
// request   | in        | start / busy                   | req_type_i, page_number_i, table_id_i
// result    | out       | result_valid_o (one cycle)     | hit_o, frame_slot_o, writeback_valid_o,
//           |           |                                | writeback_page_o, last_o
// config    | in        | psel, penable, pwrite, pready  | paddr, pwdata (prdata on reads)
//
// A lookup passes through a compare state, which checks every cell against the page number,
// then an update state, which shifts the recency stack; the single result appears in the
// cycle after the update state. In a flush the stack rotates through the head cell once, one
// entry per cycle, and every entry of the table is dropped as it passes the head; a closing
// state then ends the request, and the last result appears in the cycle after that state.
// Reset empties the pool and sets capacity to 16; no clearing pass is needed.
// Results are shown for exactly one cycle, and the receiver cannot stall them.
module lru_page_buffer_pool #(
  parameter int unsigned NUM_FRAMES = 16,
  parameter int unsigned SlotW      = 4
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // Request channel.
  input  wire                              start,
  output logic                             busy,
  input  wire                              req_type_i,
  input  wire  [lpbp_pkg::PageW-1:0]       page_number_i,
  input  wire  [lpbp_pkg::TableW-1:0]      table_id_i,
  // Result channel.
  output logic                             result_valid_o,
  output logic                             hit_o,
  output logic [SlotW-1:0]                 frame_slot_o,
  output logic                             writeback_valid_o,
  output logic [lpbp_pkg::PageW-1:0]       writeback_page_o,
  output logic                             last_o,
  // Configuration port.
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [lpbp_pkg::ApbAddrW-1:0]    paddr,
  input  wire  [lpbp_pkg::ApbDataW-1:0]    pwdata,
  output logic [lpbp_pkg::ApbDataW-1:0]    prdata,
  output logic                             pready
);

  // The used count must hold NUM_FRAMES itself; SlotW is the width of a frame index.
  localparam int unsigned CntW = $clog2(NUM_FRAMES + 1);
  localparam int unsigned CmpW = (CntW > lpbp_pkg::CapW) ? CntW : lpbp_pkg::CapW;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CMP  = 5'b00010,
    ST_UPD  = 5'b00100,
    ST_WALK = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration register. Writes must only happen while the pool is idle; the block itself does not enforce it.
  logic [lpbp_pkg::CapW-1:0] capacity_q;
  logic                      cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= lpbp_pkg::CapReset;
    end else if (cfg_write && (lpbp_pkg::reg_index_e'(paddr[2]) == lpbp_pkg::REG_CAPACITY)) begin
      capacity_q <= pwdata[lpbp_pkg::CapW-1:0];
    end
  end

  always_comb begin
    if (lpbp_pkg::reg_index_e'(paddr[2]) == lpbp_pkg::REG_CAPACITY) begin
      prdata = {{(lpbp_pkg::ApbDataW - lpbp_pkg::CapW){1'b0}}, capacity_q};
    end else begin
      prdata = '0;
    end
  end

  // Request capture.
  logic                          accept;
  logic [lpbp_pkg::PageW-1:0]    req_page_q;
  logic [lpbp_pkg::TableW-1:0]   req_table_q;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_page_q  <= page_number_i;
      req_table_q <= table_id_i;
    end
  end

  // Occupancy: the count of valid entries and a mask of slots in use.
  logic [CntW-1:0]       used_q, used_d;
  logic [NUM_FRAMES-1:0] slot_used_q, slot_used_d;
  logic [CntW-1:0]       step_q, step_d;

  // The recency chain.
  lpbp_pkg::cell_ctrl_t  ctrl;
  lpbp_pkg::entry_t      cell_cur  [NUM_FRAMES];
  logic [SlotW-1:0]      cell_slot [NUM_FRAMES];
  lpbp_pkg::entry_t      cell_pick [NUM_FRAMES];
  logic [SlotW-1:0]      cell_pick_slot [NUM_FRAMES];
  lpbp_pkg::entry_t      cell_prev [NUM_FRAMES];
  logic [SlotW-1:0]      cell_prev_slot [NUM_FRAMES];
  lpbp_pkg::entry_t      cell_next [NUM_FRAMES];
  logic [SlotW-1:0]      cell_next_slot [NUM_FRAMES];
  logic                  after_chain [NUM_FRAMES+1];

  lpbp_pkg::entry_t      head_ent;
  logic [SlotW-1:0]      head_slot;

  assign after_chain[NUM_FRAMES] = 1'b0;

  for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign cell_prev[g]      = head_ent;
      assign cell_prev_slot[g] = head_slot;
    end else begin : g_mid
      assign cell_prev[g]      = cell_cur[g-1];
      assign cell_prev_slot[g] = cell_slot[g-1];
    end
    if (g == NUM_FRAMES - 1) begin : g_last
      assign cell_next[g]      = '0;
      assign cell_next_slot[g] = '0;
    end else begin : g_inner
      assign cell_next[g]      = cell_cur[g+1];
      assign cell_next_slot[g] = cell_slot[g+1];
    end

    lpbp_cell #(
      .SlotW (SlotW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .req_page_i  (req_page_q),
      .prev_i      (cell_prev[g]),
      .prev_slot_i (cell_prev_slot[g]),
      .next_i      (cell_next[g]),
      .next_slot_i (cell_next_slot[g]),
      .wrap_i      (cell_cur[0]),
      .wrap_slot_i (cell_slot[0]),
      .after_i     (after_chain[g+1]),
      .after_o     (after_chain[g]),
      .cur_o       (cell_cur[g]),
      .cur_slot_o  (cell_slot[g]),
      .pick_o      (cell_pick[g]),
      .pick_slot_o (cell_pick_slot[g])
    );
  end

  // At most one cell is picked: the hit cell, or the tail cell on a miss.
  lpbp_pkg::entry_t pick_ent;
  logic [SlotW-1:0] pick_slot;

  always_comb begin
    pick_ent  = '0;
    pick_slot = '0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      pick_ent  = pick_ent | cell_pick[i];
      pick_slot = pick_slot | cell_pick_slot[i];
    end
  end

  // Lowest slot not in use, for a miss that fills a free frame.
  logic [SlotW-1:0] free_slot;

  always_comb begin
    free_slot = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (!slot_used_q[i]) begin
        free_slot = SlotW'(i);
      end
    end
  end

  // Eviction starts once the fill reaches the effective capacity (zero counts as one,
  // anything above the pool size counts as the pool size).
  logic [CmpW-1:0] cap_ext;
  logic [CmpW-1:0] cap_eff;
  logic            need_evict;
  logic            hit_any;
  lpbp_pkg::upd_kind_e upd_kind;

  assign cap_ext = CmpW'(capacity_q);

  always_comb begin
    if (cap_ext == '0) begin
      cap_eff = CmpW'(1);
    end else if (cap_ext > CmpW'(NUM_FRAMES)) begin
      cap_eff = CmpW'(NUM_FRAMES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign need_evict = (CmpW'(used_q) >= cap_eff);
  assign hit_any    = after_chain[0];

  always_comb begin
    if (hit_any) begin
      upd_kind = lpbp_pkg::UPD_HIT;
    end else if (need_evict) begin
      upd_kind = lpbp_pkg::UPD_EVICT;
    end else begin
      upd_kind = lpbp_pkg::UPD_INSERT;
    end
  end

  // Entry that enters the head of the stack on a lookup.
  always_comb begin
    head_ent.valid = 1'b1;
    if (hit_any) begin
      head_ent.page = pick_ent.page;
      head_ent.tbl  = pick_ent.tbl;
      head_slot     = pick_slot;
    end else begin
      head_ent.page = req_page_q;
      head_ent.tbl  = req_table_q;
      head_slot     = (upd_kind == lpbp_pkg::UPD_EVICT) ? pick_slot : free_slot;
    end
  end

  // Flush: the head entry is dropped when it belongs to the table being flushed.
  logic flush_drop;

  assign flush_drop = cell_cur[0].valid && (cell_cur[0].tbl == req_table_q);

  // A dropped entry waits in the pending register until the next drop or the end of the walk,
  // so that the final result can be marked last once the walk is over.
  logic                        pend_valid_q, pend_valid_d;
  logic [lpbp_pkg::PageW-1:0]  pend_page_q, pend_page_d;
  logic [SlotW-1:0]            pend_slot_q, pend_slot_d;

  logic                        res_valid_q, res_valid_d;
  logic                        res_hit_q, res_hit_d;
  logic [SlotW-1:0]            res_slot_q, res_slot_d;
  logic                        res_wbv_q, res_wbv_d;
  logic [lpbp_pkg::PageW-1:0]  res_wbp_q, res_wbp_d;
  logic                        res_last_q, res_last_d;

  always_comb begin
    state_d        = state_q;
    used_d         = used_q;
    slot_used_d    = slot_used_q;
    step_d         = step_q;
    pend_valid_d   = pend_valid_q;
    pend_page_d    = pend_page_q;
    pend_slot_d    = pend_slot_q;
    res_valid_d    = 1'b0;
    res_hit_d      = res_hit_q;
    res_slot_d     = res_slot_q;
    res_wbv_d      = res_wbv_q;
    res_wbp_d      = res_wbp_q;
    res_last_d     = res_last_q;
    ctrl.op        = lpbp_pkg::OP_HOLD;
    ctrl.kind      = upd_kind;
    ctrl.keep      = !flush_drop;
    ctrl.pick_tail = !hit_any;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          step_d = used_q;
          if (lpbp_pkg::req_type_e'(req_type_i) == lpbp_pkg::REQ_LOOKUP) begin
            state_d = ST_CMP;
          end else if (used_q == '0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_CMP: begin
        ctrl.op = lpbp_pkg::OP_CMP;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        ctrl.op     = lpbp_pkg::OP_SHIFT;
        res_valid_d = 1'b1;
        res_hit_d   = hit_any;
        res_slot_d  = head_slot;
        res_last_d  = 1'b1;
        res_wbv_d   = (upd_kind == lpbp_pkg::UPD_EVICT);
        res_wbp_d   = (upd_kind == lpbp_pkg::UPD_EVICT) ? pick_ent.page : '0;
        if (upd_kind == lpbp_pkg::UPD_INSERT) begin
          used_d                 = used_q + CntW'(1);
          slot_used_d[free_slot] = 1'b1;
        end
        state_d = ST_IDLE;
      end
      ST_WALK: begin
        ctrl.op = lpbp_pkg::OP_ROT;
        if (flush_drop) begin
          used_d                    = used_q - CntW'(1);
          slot_used_d[cell_slot[0]] = 1'b0;
          if (pend_valid_q) begin
            res_valid_d = 1'b1;
            res_hit_d   = 1'b0;
            res_slot_d  = pend_slot_q;
            res_wbv_d   = 1'b1;
            res_wbp_d   = pend_page_q;
            res_last_d  = 1'b0;
          end
          pend_valid_d = 1'b1;
          pend_page_d  = cell_cur[0].page;
          pend_slot_d  = cell_slot[0];
        end
        step_d = step_q - CntW'(1);
        if (step_q == CntW'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // An empty flush still answers with one result that carries no write-back.
        res_valid_d  = 1'b1;
        res_hit_d    = 1'b0;
        res_slot_d   = pend_valid_q ? pend_slot_q : '0;
        res_wbv_d    = pend_valid_q;
        res_wbp_d    = pend_valid_q ? pend_page_q : '0;
        res_last_d   = 1'b1;
        pend_valid_d = 1'b0;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      used_q       <= '0;
      slot_used_q  <= '0;
      step_q       <= '0;
      pend_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      used_q       <= used_d;
      slot_used_q  <= slot_used_d;
      step_q       <= step_d;
      pend_valid_q <= pend_valid_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_page_q <= pend_page_d;
    pend_slot_q <= pend_slot_d;
    res_hit_q   <= res_hit_d;
    res_slot_q  <= res_slot_d;
    res_wbv_q   <= res_wbv_d;
    res_wbp_q   <= res_wbp_d;
    res_last_q  <= res_last_d;
  end

  assign result_valid_o    = res_valid_q;
  assign hit_o             = res_hit_q;
  assign frame_slot_o      = res_slot_q;
  assign writeback_valid_o = res_wbv_q;
  assign writeback_page_o  = res_wbp_q;
  assign last_o            = res_last_q;

  // The slot mask and the fill count must always agree.
  a_used_matches_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(slot_used_q) == int'(used_q))
    else $error("slot mask and used count disagree");

  a_used_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(NUM_FRAMES))
    else $error("used count beyond pool size");

  // Every request ends with a last result in the cycle the pool goes idle.
  a_idle_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (result_valid_o && last_o))
    else $error("request finished without a last result");

  a_lookup_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (lpbp_pkg::req_type_e'(req_type_i) == lpbp_pkg::REQ_LOOKUP))
      |-> ##3 (result_valid_o && last_o))
    else $error("lookup result missing");

  a_hit_no_writeback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && hit_o) |-> !writeback_valid_o)
    else $error("hit reported a write-back");

endmodule

`default_nettype wire

FILE: hdl/lpbp_cell.sv
`default_nettype none

// One position of the recency stack. Position 0 is the most recent entry.
module lpbp_cell #(
  parameter int unsigned SlotW = 4
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  lpbp_pkg::cell_ctrl_t            ctrl_i,
  input  wire  [lpbp_pkg::PageW-1:0]      req_page_i,
  input  lpbp_pkg::entry_t                prev_i,
  input  wire  [SlotW-1:0]                prev_slot_i,
  input  lpbp_pkg::entry_t                next_i,
  input  wire  [SlotW-1:0]                next_slot_i,
  input  lpbp_pkg::entry_t                wrap_i,
  input  wire  [SlotW-1:0]                wrap_slot_i,
  input  wire                             after_i,
  output logic                            after_o,
  output lpbp_pkg::entry_t                cur_o,
  output logic [SlotW-1:0]                cur_slot_o,
  output lpbp_pkg::entry_t                pick_o,
  output logic [SlotW-1:0]                pick_slot_o
);

  lpbp_pkg::entry_t  cur_q, cur_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic              match_q, match_d;
  logic              shift_en;
  logic              is_tail;
  logic              pick_en;

  // The last valid position is the tail, since valid entries stay packed at the head.
  assign is_tail = cur_q.valid && !next_i.valid;
  assign after_o = match_q || after_i;
  assign pick_en = match_q || (ctrl_i.pick_tail && is_tail);

  always_comb begin
    cur_d    = cur_q;
    slot_d   = slot_q;
    match_d  = match_q;
    shift_en = 1'b0;
    case (ctrl_i.op)
      lpbp_pkg::OP_CMP: begin
        match_d = cur_q.valid && (cur_q.page == req_page_i);
      end
      lpbp_pkg::OP_SHIFT: begin
        case (ctrl_i.kind)
          lpbp_pkg::UPD_HIT:    shift_en = match_q || after_i;
          lpbp_pkg::UPD_INSERT: shift_en = prev_i.valid;
          default:              shift_en = cur_q.valid;
        endcase
        if (shift_en) begin
          cur_d  = prev_i;
          slot_d = prev_slot_i;
        end
      end
      lpbp_pkg::OP_ROT: begin
        if (ctrl_i.keep && is_tail) begin
          cur_d  = wrap_i;
          slot_d = wrap_slot_i;
        end else begin
          cur_d  = next_i;
          slot_d = next_slot_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      match_q <= 1'b0;
    end else begin
      cur_q   <= cur_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign cur_o       = cur_q;
  assign cur_slot_o  = slot_q;
  assign pick_o      = pick_en ? cur_q : '0;
  assign pick_slot_o = pick_en ? slot_q : '0;

endmodule

`default_nettype wire

FILE: verif/tb_lru_page_buffer_pool.sv
`timescale 1ns / 100ps

module tb_lru_page_buffer_pool;

  localparam int NumFrames  = 16;
  localparam int SlotW      = 4;
  localparam int NumDirected = 26;
  // The limit leaves a wide margin over the slowest correct run of roughly 340 requests.
  localparam int unsigned CycleLimit = 200000;

  localparam int unsigned PageW    = lpbp_pkg::PageW;
  localparam int unsigned TableW   = lpbp_pkg::TableW;
  localparam int unsigned CapW     = lpbp_pkg::CapW;
  localparam int unsigned ApbAddrW = lpbp_pkg::ApbAddrW;
  localparam int unsigned ApbDataW = lpbp_pkg::ApbDataW;

  // One result of the pool as it leaves the result channel.
  typedef struct packed {
    logic              hit;
    logic [SlotW-1:0]  slot;
    logic              wb_valid;
    logic [PageW-1:0]  wb_page;
    logic              last;
  } frame_report_t;

  // A row of the directed table either issues a request or rewrites the capacity register.
  // For a register row the page column carries the word written over the bus.
  typedef enum bit {
    ROW_REQUEST,
    ROW_CAPACITY
  } row_kind_e;

  typedef struct {
    row_kind_e           kind;
    lpbp_pkg::req_type_e rq;
    logic [PageW-1:0]    page;
    logic [TableW-1:0]   tbl;
    bit                  has_fixed;
    frame_report_t       fixed;
  } stim_row_t;

  localparam frame_report_t NoReport = '0;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                req_type_i;
  logic [PageW-1:0]    page_number_i;
  logic [TableW-1:0]   table_id_i;
  logic                result_valid_o;
  logic                hit_o;
  logic [SlotW-1:0]    frame_slot_o;
  logic                writeback_valid_o;
  logic [PageW-1:0]    writeback_page_o;
  logic                last_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  lru_page_buffer_pool #(
    .NUM_FRAMES(NumFrames),
    .SlotW     (SlotW)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type_i),
    .page_number_i    (page_number_i),
    .table_id_i       (table_id_i),
    .result_valid_o   (result_valid_o),
    .hit_o            (hit_o),
    .frame_slot_o     (frame_slot_o),
    .writeback_valid_o(writeback_valid_o),
    .writeback_page_o (writeback_page_o),
    .last_o           (last_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Free-running clock with a period of 2 ns.
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------------------
  // Software copy of the pool. It is updated when a request is accepted and pushes every
  // result that request must produce onto frame_reports_q, oldest first.
  // ---------------------------------------------------------------------------------------
  bit                pool_valid [NumFrames];
  logic [PageW-1:0]  pool_page  [NumFrames];
  logic [TableW-1:0] pool_tbl   [NumFrames];
  logic [3:0]        pool_rank  [NumFrames];
  logic [CapW-1:0]   pool_used;
  logic [CapW-1:0]   pool_capacity;

  frame_report_t frame_reports_q [$];
  int unsigned   mismatches;
  int unsigned   cycle_count;

  // The entry at slot s becomes the most recent; every valid entry that was more recent
  // than it ages by one step, the older ones keep their rank.
  function automatic void make_most_recent(int s);
    logic [3:0] r;
    r = pool_rank[s];
    for (int i = 0; i < NumFrames; i++) begin
      if (pool_valid[i] && i != s && pool_rank[i] < r) pool_rank[i]++;
    end
    pool_rank[s] = '0;
  endfunction

  function automatic void apply_lookup(logic [PageW-1:0] pg, logic [TableW-1:0] tb);
    int              slot;
    int              free_slot;
    int              victim;
    logic [3:0]      worst;
    logic [CapW-1:0] limit;
    logic [PageW-1:0] old_page;
    slot      = -1;
    free_slot = -1;
    victim    = -1;
    worst     = '0;
    // A hit matches on the page number alone; the table tag of the entry is kept.
    for (int i = 0; i < NumFrames; i++) begin
      if (slot < 0 && pool_valid[i] && pool_page[i] == pg) slot = i;
    end
    if (slot >= 0) begin
      make_most_recent(slot);
      frame_reports_q.push_back(frame_report_t'{1'b1, SlotW'(slot), 1'b0, '0, 1'b1});
      return;
    end
    for (int i = 0; i < NumFrames; i++) begin
      if (free_slot < 0 && !pool_valid[i]) free_slot = i;
    end
    // A capacity of zero acts as one, anything above the frame count as the frame count.
    if (pool_capacity == '0) limit = CapW'(1);
    else if (pool_capacity > NumFrames) limit = CapW'(NumFrames);
    else limit = pool_capacity;
    if (pool_used >= limit || free_slot < 0) begin
      // The least recent entry is replaced in place, so the fill never shrinks here.
      for (int i = 0; i < NumFrames; i++) begin
        if (pool_valid[i] && (victim < 0 || pool_rank[i] > worst)) begin
          victim = i;
          worst  = pool_rank[i];
        end
      end
      old_page          = pool_page[victim];
      pool_page[victim] = pg;
      pool_tbl[victim]  = tb;
      make_most_recent(victim);
      frame_reports_q.push_back(frame_report_t'{1'b0, SlotW'(victim), 1'b1, old_page, 1'b1});
      return;
    end
    pool_valid[free_slot] = 1'b1;
    pool_page[free_slot]  = pg;
    pool_tbl[free_slot]   = tb;
    pool_rank[free_slot]  = pool_used[3:0];
    pool_used++;
    make_most_recent(free_slot);
    frame_reports_q.push_back(frame_report_t'{1'b0, SlotW'(free_slot), 1'b0, '0, 1'b1});
  endfunction

  function automatic void apply_flush(logic [TableW-1:0] tb);
    int         order [$];
    logic [3:0] new_rank [NumFrames];
    // Entries of the table leave most recent first.
    for (int r = 0; r < NumFrames; r++) begin
      for (int i = 0; i < NumFrames; i++) begin
        if (pool_valid[i] && pool_tbl[i] == tb && pool_rank[i] == r) order.push_back(i);
      end
    end
    if (order.size() == 0) begin
      // Nothing buffered for that table: a single empty result closes the request.
      frame_reports_q.push_back(frame_report_t'{1'b0, '0, 1'b0, '0, 1'b1});
      return;
    end
    foreach (order[k]) begin
      frame_reports_q.push_back(frame_report_t'{1'b0, SlotW'(order[k]), 1'b1,
                                                pool_page[order[k]], k == order.size() - 1});
      pool_valid[order[k]] = 1'b0;
      if (pool_used > 0) pool_used--;
    end
    // The survivors close ranks while keeping their order.
    for (int i = 0; i < NumFrames; i++) begin
      new_rank[i] = '0;
      if (pool_valid[i]) begin
        for (int j = 0; j < NumFrames; j++) begin
          if (pool_valid[j] && pool_rank[j] < pool_rank[i]) new_rank[i]++;
        end
      end
    end
    for (int i = 0; i < NumFrames; i++) pool_rank[i] = new_rank[i];
  endfunction

  // ---------------------------------------------------------------------------------------
  // Request side. Every task here is entered at a rising edge and returns at one, so all
  // inputs change right after an edge and are stable when the block samples them.
  // ---------------------------------------------------------------------------------------

  // Presents one request and holds it until it is taken, then updates the software pool.
  // start is only ever raised here, so a request that follows straight on in the same time
  // step leaves it high instead of dropping and raising it again.
  task automatic issue_request(lpbp_pkg::req_type_e rq, logic [PageW-1:0] pg,
                               logic [TableW-1:0] tb);
    start         <= 1'b1;
    req_type_i    <= rq;
    page_number_i <= pg;
    table_id_i    <= tb;
    do @(posedge clk_i); while (busy !== 1'b0);
    if (rq == lpbp_pkg::REQ_LOOKUP) apply_lookup(pg, tb);
    else apply_flush(tb);
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Waits until every outstanding result has come back and the block has gone idle.
  task automatic drain_pool();
    start <= 1'b0;
    do @(posedge clk_i); while (frame_reports_q.size() != 0 || busy !== 1'b0);
  endtask

  // Setup cycle, then access cycle; the register takes the word at the edge where pready
  // is seen high with the access phase. Only the low bits of the word reach the register.
  task automatic write_capacity(logic [ApbDataW-1:0] word);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {lpbp_pkg::REG_CAPACITY, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pool_capacity = word[CapW-1:0];
  endtask

  // Random traffic in bursts. Lookups mostly draw from a small working set of random pages
  // and a handful of tables, so hits, evictions and multi-entry flushes all happen often;
  // the rest are fully random pages and tables that mostly miss or flush nothing.
  task automatic random_phase(int count);
    logic [PageW-1:0]  work_pages [24];
    logic [PageW-1:0]  pg;
    logic [TableW-1:0] tb;
    int                ws;
    int                burst_left;
    int                roll;
    foreach (work_pages[i]) work_pages[i] = $urandom;
    ws         = $urandom_range(4, 24);
    burst_left = 0;
    for (int n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        // Now and then a long stretch runs without any gap at all.
        if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(20, 40);
        else burst_left = $urandom_range(1, 8);
        pause_sender($urandom_range(1, 12));
      end
      burst_left--;
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        tb = (roll < 3) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3));
        issue_request(lpbp_pkg::REQ_FLUSH, $urandom, tb);
      end else begin
        pg = (roll < 18) ? $urandom : work_pages[$urandom_range(0, ws - 1)];
        tb = (roll < 24) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3));
        issue_request(lpbp_pkg::REQ_LOOKUP, pg, tb);
      end
      // Occasionally hold off until the pool has answered everything.
      if ($urandom_range(0, 49) == 0) drain_pool();
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Directed table. The fixed result is filled in only where it is plain from the pool's
  // state; the other rows are checked through the software pool.
  // ---------------------------------------------------------------------------------------
  stim_row_t directed_rows [NumDirected] = '{
    // Empty pool at the reset capacity of 16: a flush of an absent table, then fills and
    // a hit on a page that is asked for under a different table.
    '{ROW_REQUEST,  lpbp_pkg::REQ_FLUSH,  32'h0000_0000, 8'h00, 1'b1,
      '{1'b0, 4'd0, 1'b0, 32'h0, 1'b1}},
    '{ROW_REQUEST,  lpbp_pkg::REQ_LOOKUP, 32'h0000_0000, 8'h00, 1'b1,
      '{1'b0, 4'd0, 1'b0, 32'h0, 1'b1}},
    '{ROW_REQUEST,  lpbp_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 8'hFF, 1'b1,
      '{1'b0, 4'd1, 1'b0, 32'h0, 1'b1}},
    '{ROW_REQUEST,  lpbp_pkg::REQ_LOOKUP, 32'h0000_0000, 8'h05, 1'b1,
      '{1'b1, 4'd0, 1'b0, 32'h0, 1'b1}},
    '{ROW_REQUEST,  lpbp_pkg::REQ_LOOKUP, 32'h1234_5678, 8'hFF, 1'b1,
      '{1'b0, 4'd2, 1'b0, 32'h0, 1'b1}},
    '{ROW_REQUEST,  lpbp_pkg::REQ_FLUSH,  32'h0000_0000, 8'hFF, 1'b0, NoReport},
    '{ROW_REQUEST,  lpbp_pkg::REQ_FLUSH,  32'h0000_0000, 8'h00, 1'b0, NoReport},
    // A single frame: the first miss fills it, every later miss replaces the one entry.
    '{ROW_CAPACITY, lpbp_pkg::REQ_LOOKUP, 32'h0000_0001, 8'h00, 1'b0, NoReport},
    '{ROW_REQUEST,  lpbp_pkg::REQ_LOOKUP, 32'hA5A5_A5A5, 8'h01, 1'b1,
      '{1'b0, 4'd0, 1'b0, 32'h0, 1'b1}},
    '{ROW_REQUEST,  lpbp_pkg::REQ_LOOKUP, 32'h5A5A_5A5A, 8'h02, 1'b1,
      '{1'b0, 4'd0, 1'b1, 32'hA5A5_A5A5, 1'b1}},
    '{ROW_REQUEST,  lpbp_pkg::REQ_LOOKUP, 32'h5A5A_5A5A, 8'h03, 1'b1,
      '{1'b1, 4'd0, 1'b0, 32'h0, 1'b1}},
    // Capacity zero behaves as one; the upper bits of the written word are ignored.
    '{ROW_CAPACITY, lpbp_pkg::REQ_LOOKUP, 32'hFFFF_FFE0, 8'h00, 1'b0, NoReport},
    '{ROW_REQUEST,  lpbp_pkg::REQ_LOOKUP, 32'h0000_0001, 8'h04, 1'b1,
      '{1'b0, 4'd0, 1'b1, 32'h5A5A_5A5A, 1'b1}},
    // Capacity above the frame count behaves as the frame count.
    '{ROW_CAPACITY, lpbp_pkg::REQ_LOOKUP, 32'h0000_001F, 8'h00, 1'b0, NoReport},
    '{ROW_REQUEST,  lpbp_pkg::REQ_LOOKUP, 32'h0000_0002, 8'h04, 1'b0, NoReport},
    '{ROW_REQUEST,  lpbp_pkg::REQ_LOOKUP, 32'h0000_0003, 8'h04, 1'b0, NoReport},
    '{ROW_REQUEST,  lpbp_pkg::REQ_FLUSH,  32'h0000_0000, 8'h04, 1'b0, NoReport},
    // Fill three frames, then drop the capacity below the fill.
    '{ROW_REQUEST,  lpbp_pkg::REQ_LOOKUP, 32'h0000_0010, 8'h07, 1'b0, NoReport},
    '{ROW_REQUEST,  lpbp_pkg::REQ_LOOKUP, 32'h0000_0011, 8'h07, 1'b0, NoReport},
    '{ROW_REQUEST,  lpbp_pkg::REQ_LOOKUP, 32'h0000_0012, 8'h08, 1'b0, NoReport},
    '{ROW_CAPACITY, lpbp_pkg::REQ_LOOKUP, 32'h0000_0002, 8'h00, 1'b0, NoReport},
    '{ROW_REQUEST,  lpbp_pkg::REQ_LOOKUP, 32'h0000_0013, 8'h08, 1'b0, NoReport},
    '{ROW_REQUEST,  lpbp_pkg::REQ_LOOKUP, 32'h0000_0011, 8'h08, 1'b0, NoReport},
    '{ROW_REQUEST,  lpbp_pkg::REQ_FLUSH,  32'h0000_0000, 8'h08, 1'b0, NoReport},
    '{ROW_REQUEST,  lpbp_pkg::REQ_FLUSH,  32'h0000_0000, 8'h09, 1'b1,
      '{1'b0, 4'd0, 1'b0, 32'h0, 1'b1}},
    '{ROW_REQUEST,  lpbp_pkg::REQ_FLUSH,  32'h0000_0000, 8'h07, 1'b0, NoReport}
  };

  // ---------------------------------------------------------------------------------------
  // Result checker. A result is taken at the edge that ends its cycle, so the outputs are
  // read here before the block updates them for the next cycle.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk_i) begin
    frame_report_t want;
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      if (frame_reports_q.size() == 0) begin
        $error("result with no request outstanding: slot %0d page %h",
               frame_slot_o, writeback_page_o);
        mismatches++;
      end else begin
        want = frame_reports_q.pop_front();
        if (hit_o !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit_o);
          mismatches++;
        end
        if (frame_slot_o !== want.slot) begin
          $error("frame_slot: expected %0d, got %0d", want.slot, frame_slot_o);
          mismatches++;
        end
        if (writeback_valid_o !== want.wb_valid) begin
          $error("writeback_valid: expected %0d, got %0d", want.wb_valid, writeback_valid_o);
          mismatches++;
        end
        if (writeback_page_o !== want.wb_page) begin
          $error("writeback_page: expected %h, got %h", want.wb_page, writeback_page_o);
          mismatches++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Main sequence: reset, the directed table, then random phases, each under a new
  // capacity written while the pool is idle. The pool is not emptied between phases, so a
  // lower capacity often lands on a fuller pool.
  // ---------------------------------------------------------------------------------------
  initial begin
    stim_row_t       row;
    logic [CapW-1:0] cap_plan [6];
    logic [ApbDataW-1:0] word;
    cap_plan      = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd17};
    mismatches    = 0;
    cycle_count   = 0;
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    req_type_i    <= lpbp_pkg::REQ_LOOKUP;
    page_number_i <= '0;
    table_id_i    <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    foreach (pool_valid[i]) begin
      pool_valid[i] = 1'b0;
      pool_page[i]  = '0;
      pool_tbl[i]   = '0;
      pool_rank[i]  = '0;
    end
    pool_used     = '0;
    pool_capacity = lpbp_pkg::CapReset;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumDirected; r++) begin
      row = directed_rows[r];
      if (row.kind == ROW_CAPACITY) begin
        drain_pool();
        write_capacity(row.page);
      end else begin
        issue_request(row.rq, row.page, row.tbl);
        // Rows with a fixed result give exactly one; it replaces the computed one.
        if (row.has_fixed) frame_reports_q[frame_reports_q.size() - 1] = row.fixed;
      end
    end

    for (int p = 0; p < 8; p++) begin
      drain_pool();
      // Random upper bits go along with the capacity; the register keeps the low bits.
      word = $urandom;
      word[CapW-1:0] = (p < 6) ? cap_plan[p] : CapW'($urandom_range(0, 31));
      write_capacity(word);
      random_phase(40);
    end

    drain_pool();
    // The extra wait catches any stray result after the last expected one.
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
